FILE: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg - rational arithmetic unit shared definitions
// Operation codes and word widths for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 3;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_kind KIND_ADD = 3'd0;
    localparam t_kind KIND_SUB = 3'd1;
    localparam t_kind KIND_MUL = 3'd2;
    localparam t_kind KIND_DIV = 3'd3;
    localparam t_kind KIND_CMP = 3'd4;
endpackage
`default_nettype wire

FILE: rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit - add, subtract, multiply, divide, compare fractions
// Cross-multiplies two signed fractions and reduces by the Euclidean GCD,
// using one shared 32x32 multiplier and one bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  input   | i_valid / o_ready  | i_kind i_a_num i_a_den i_b_num i_b_den
//  output  | o_valid / i_ready  | o_res_num o_res_den o_div_by_zero
//          |                    | o_is_equal o_is_greater
//
// One transaction at a time. Three product states on the shared multiplier
// and one decision state, then each GCD remainder step and each of the two
// final quotients runs on the shared restoring divider. A zero denominator
// product skips the GCD loop; pass-through, compare, zero-product, zero
// divisor and unused kinds skip the divider. Reset clears the sequencer,
// the divider and the valid flag; payload registers hold. A finished result
// waits in the output register; o_ready stays low until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  rau_pkg::t_kind    i_kind,
    input  rau_pkg::t_word    i_a_num,
    input  rau_pkg::t_word    i_a_den,
    input  rau_pkg::t_word    i_b_num,
    input  rau_pkg::t_word    i_b_den,
    output logic              o_valid,
    input  wire               i_ready,
    output rau_pkg::t_word    o_res_num,
    output rau_pkg::t_word    o_res_den,
    output logic              o_div_by_zero,
    output logic              o_is_equal,
    output logic              o_is_greater
);
    import rau_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;  // first product
    localparam logic [3:0] S_MUL1  = 4'd2;  // second product
    localparam logic [3:0] S_MUL2  = 4'd3;  // denominator product / combine
    localparam logic [3:0] S_PREP  = 4'd4;  // decide reduce path
    localparam logic [3:0] S_GCD   = 4'd5;  // remainder steps
    localparam logic [3:0] S_QNUM  = 4'd6;  // numerator / g
    localparam logic [3:0] S_QDEN  = 4'd7;  // denominator / g
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int unsigned CNT_W = $clog2(WORD_W + 1);

    logic [3:0]  r_state, n_state;
    t_kind       r_kind;
    t_word       r_an, r_ad, r_bn, r_bd;
    t_word       r_p, r_q, r_m, r_d;
    t_word       r_x, r_y, r_g;
    logic        r_o_valid;
    t_word       r_res_num, r_res_den;
    logic        r_dz, r_eq, r_gt;

    // shared divider: restoring, one quotient bit per cycle
    logic        r_dv_busy;
    logic [CNT_W-1:0] r_dv_cnt;
    t_word       r_dv_quo, r_dv_rem, r_dv_den;
    logic        dv_start;
    t_word       dv_a, dv_b;
    logic [WORD_W:0] dv_trial;
    logic        dv_done;

    // shared multiplier, low word only (products wrap at 32 bits)
    t_word       mul_a, mul_b, mul_p;

    // decision for the current operands
    logic        prep_reduce;
    t_word       neg_bn;

    function automatic t_word mag(input t_word v);
        mag = v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign mul_p  = mul_a * mul_b;
    assign neg_bn = ~r_bn + 1'b1;

    always_comb begin
        unique case (r_state)
            S_MUL0:  begin
                mul_a = r_an;
                mul_b = (r_kind == KIND_MUL) ? r_bn : r_bd;
            end
            S_MUL1:  begin
                mul_a = r_ad;
                mul_b = (r_kind == KIND_MUL) ? r_bd : r_bn;
            end
            default: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
        endcase
    end

    // Reduce unless a pass-through, a zero product, a zero divisor or compare.
    always_comb begin
        unique case (r_kind)
            KIND_ADD, KIND_SUB: prep_reduce = (r_an != '0) && (r_bn != '0);
            KIND_MUL: prep_reduce = (r_m != '0) && (r_d != '0);
            KIND_DIV: prep_reduce = (r_bn != '0) && (r_m != '0) && (r_d != '0);
            default:  prep_reduce = 1'b0;
        endcase
    end

    assign dv_trial = {r_dv_rem[WORD_W-2:0], r_dv_quo[WORD_W-1]} - {1'b0, r_dv_den};
    assign dv_done  = r_dv_busy && (r_dv_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (dv_start) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= CNT_W'(WORD_W);
            r_dv_quo  <= dv_a;
            r_dv_rem  <= '0;
            r_dv_den  <= dv_b;
        end else if (r_dv_busy) begin
            if (r_dv_cnt == '0) begin
                r_dv_busy <= 1'b0;
            end else begin
                r_dv_cnt <= r_dv_cnt - 1'b1;
                if (!dv_trial[WORD_W]) begin
                    r_dv_rem <= dv_trial[WORD_W-1:0];
                    r_dv_quo <= {r_dv_quo[WORD_W-2:0], 1'b1};
                end else begin
                    r_dv_rem <= {r_dv_rem[WORD_W-2:0], r_dv_quo[WORD_W-1]};
                    r_dv_quo <= {r_dv_quo[WORD_W-2:0], 1'b0};
                end
            end
        end
    end

    // next state and divider operands by state
    always_comb begin
        dv_start = 1'b0;
        dv_a     = r_x;
        dv_b     = r_y;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_PREP;
            S_PREP: begin
                // zero denominator product: skip the remainder loop
                if (!prep_reduce) n_state = S_DONE;
                else if (r_d == '0) n_state = S_QNUM;
                else n_state = S_GCD;
            end
            S_GCD: if (!r_dv_busy) begin
                dv_start = 1'b1;
            end else if (dv_done && (r_dv_rem == '0)) begin
                n_state = S_QNUM;
            end
            S_QNUM: if (!r_dv_busy) begin
                dv_start = 1'b1;
                dv_a     = mag(r_m);
                dv_b     = r_g;
            end else if (dv_done) n_state = S_QDEN;
            S_QDEN: if (!r_dv_busy) begin
                dv_start = 1'b1;
                dv_a     = mag(r_d);
                dv_b     = r_g;
            end else if (dv_done) n_state = S_DONE;
            S_DONE: if (i_ready && r_o_valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_kind <= i_kind; r_an <= i_a_num; r_ad <= i_a_den;
                    r_bn <= i_b_num; r_bd <= i_b_den;
                    r_res_num <= '0; r_res_den <= '0;
                    r_dz <= 1'b0; r_eq <= 1'b0; r_gt <= 1'b0;
                end
                S_MUL0: r_p <= mul_p;
                S_MUL1: r_q <= mul_p;
                S_MUL2: begin
                    if (r_kind == KIND_SUB || r_kind == KIND_CMP) begin
                        r_m <= r_p - r_q;
                        r_d <= mul_p;
                    end else if (r_kind == KIND_ADD) begin
                        r_m <= r_p + r_q;
                        r_d <= mul_p;
                    end else begin
                        r_m <= r_p;
                        r_d <= r_q;
                    end
                end
                S_PREP: begin
                    // GCD seeds; with a zero denominator the divisor is |m|
                    r_x <= mag(r_m);
                    r_y <= mag(r_d);
                    r_g <= (r_m == '0) ? t_word'(1) : mag(r_m);
                    // negative divisor: flip both products before reducing
                    if (r_kind == KIND_DIV && r_bn[WORD_W-1]) begin
                        r_m <= ~r_m + 1'b1;
                        r_d <= ~r_d + 1'b1;
                    end
                    if (r_kind == KIND_ADD || r_kind == KIND_SUB) begin
                        if (r_an == '0) begin
                            r_res_num <= (r_kind == KIND_ADD) ? r_bn : neg_bn;
                            r_res_den <= r_bd;
                        end else if (r_bn == '0) begin
                            r_res_num <= r_an; r_res_den <= r_ad;
                        end
                    end
                    if (r_kind == KIND_CMP) begin
                        r_eq <= (r_an == r_bn) && (r_an == '0 || r_ad == r_bd);
                        // sign of the difference numerator decides greater
                        if (r_an == '0) r_gt <= (neg_bn != '0) && !neg_bn[WORD_W-1];
                        else if (r_bn == '0) r_gt <= !r_an[WORD_W-1];
                        else r_gt <= (r_m != '0) && !r_m[WORD_W-1];
                    end
                    if (r_kind == KIND_DIV && r_bn == '0) begin
                        r_res_num <= r_an; r_res_den <= r_ad; r_dz <= 1'b1;
                    end
                    if (!prep_reduce) r_o_valid <= 1'b1;
                end
                S_GCD: if (dv_done) begin
                    if (r_dv_rem == '0) r_g <= r_y;
                    else begin
                        r_x <= r_y; r_y <= r_dv_rem;
                    end
                end
                S_QNUM: if (dv_done) r_res_num <= r_m[WORD_W-1] ? (~r_dv_quo + 1'b1) : r_dv_quo;
                S_QDEN: if (dv_done) begin
                    r_res_den <= r_d[WORD_W-1] ? (~r_dv_quo + 1'b1) : r_dv_quo;
                    r_o_valid <= 1'b1;
                end
                S_DONE: if (i_ready && r_o_valid) r_o_valid <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_res_num     = r_res_num;
    assign o_res_den     = r_res_den;
    assign o_div_by_zero = r_dz;
    assign o_is_equal    = r_eq;
    assign o_is_greater  = r_gt;
endmodule
`default_nettype wire
